FILE: design/cla_pkg.sv
`default_nettype none

package cla_pkg;

    localparam int MAX_BACKSLASH_RUN_DEF = 4095;
    localparam int MAX_ARGS_DEF          = 255;

    // bundles held between parser and output serialiser
    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_RES     = 3;

    localparam logic [15:0] CH_SPACE  = 16'h0020;
    localparam logic [15:0] CH_TAB    = 16'h0009;
    localparam logic [15:0] CH_QUOTE  = 16'h0022;
    localparam logic [15:0] CH_BSLASH = 16'h005C;

    localparam logic [1:0] RK_TEXT     = 2'd0;
    localparam logic [1:0] RK_END_ARG  = 2'd1;
    localparam logic [1:0] RK_END_LINE = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] unit;
        logic [11:0] rep;
        logic [7:0]  idx;
    } t_res;

    // results caused by one input item, n of them valid
    typedef struct packed {
        t_res [MAX_RES-1:0] res;
        logic [1:0]         n;
    } t_bundle;

    function automatic t_res mk_res(input logic [1:0] kind, input logic [15:0] unit,
                                    input logic [11:0] rep, input logic [7:0] idx);
        t_res r;
        r.kind = kind;
        r.unit = unit;
        r.rep  = rep;
        r.idx  = idx;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/cla_if.sv
`default_nettype none

interface cla_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] code_unit;

    modport source (output valid, output kind, output code_unit, input ready);
    modport sink   (input valid, input kind, input code_unit, output ready);
endinterface

interface cla_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [15:0] out_unit;
    logic [11:0] repeat_res;
    logic [7:0]  arg_index;
    logic        last;

    modport source (output valid, output result_kind, output out_unit,
                    output repeat_res, output arg_index, output last, input ready);
    modport sink   (input valid, input result_kind, input out_unit,
                    input repeat_res, input arg_index, input last, output ready);
endinterface

`default_nettype wire

FILE: design/cla_front.sv
`default_nettype none

module cla_front
    import cla_pkg::*;
#(
    parameter int MAX_BACKSLASH_RUN = MAX_BACKSLASH_RUN_DEF,
    parameter int MAX_ARGS          = MAX_ARGS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cla_in_if.sink    i_in,
    input  wire logic i_q_ready,
    output logic      o_push,
    output t_bundle   o_bundle
);

    localparam int BW = $clog2(MAX_BACKSLASH_RUN + 1);
    localparam int CW = $clog2(MAX_ARGS + 1);

    typedef enum logic [3:0] {
        M_LEAD = 4'b0001,
        M_PROG = 4'b0010,
        M_GAP  = 4'b0100,
        M_ARG  = 4'b1000
    } t_mode;

    t_mode         r_mode, n_mode;
    logic          r_inq, n_inq;
    logic          r_qp, n_qp;
    logic [BW-1:0] r_run, n_run;
    logic [CW-1:0] r_cnt, n_cnt;

    logic [BW-1:0] run_tmp;
    logic          stop, do_later, blank, acc;
    logic [15:0]   c;
    t_bundle       b;

    assign c     = i_in.code_unit;
    assign blank = (c == CH_SPACE) || (c == CH_TAB);
    assign acc   = i_in.valid && i_q_ready;

    always_comb begin
        n_mode   = r_mode;
        n_inq    = r_inq;
        n_qp     = r_qp;
        n_run    = r_run;
        n_cnt    = r_cnt;
        run_tmp  = '0;
        stop     = 1'b0;
        do_later = 1'b0;
        b        = '0;

        if (i_in.kind) begin
            if (r_mode == M_ARG && r_run != '0) begin
                b.res[b.n] = mk_res(RK_TEXT, CH_BSLASH, 12'(r_run), 8'(n_cnt));
                b.n = b.n + 2'd1;
            end
            // program name always exists, even on an empty line
            if (r_mode != M_GAP) begin
                b.res[b.n] = mk_res(RK_END_ARG, '0, '0, 8'(n_cnt));
                b.n = b.n + 2'd1;
                if (n_cnt < CW'(MAX_ARGS)) n_cnt = n_cnt + CW'(1);
            end
            b.res[b.n] = mk_res(RK_END_LINE, '0, '0, 8'(n_cnt));
            b.n    = b.n + 2'd1;
            n_mode = M_LEAD;
            n_inq  = 1'b0;
            n_qp   = 1'b0;
            n_run  = '0;
            n_cnt  = '0;
        end else begin
            unique case (r_mode)
                M_LEAD, M_PROG: begin
                    if (!(r_mode == M_LEAD && blank)) begin
                        n_mode = M_PROG;
                        if (c == CH_QUOTE) begin
                            n_inq = !n_inq;
                        end else if (!n_inq && blank) begin
                            b.res[b.n] = mk_res(RK_END_ARG, '0, '0, 8'(n_cnt));
                            b.n = b.n + 2'd1;
                            if (n_cnt < CW'(MAX_ARGS)) n_cnt = n_cnt + CW'(1);
                            n_inq  = 1'b0;
                            n_qp   = 1'b0;
                            n_run  = '0;
                            n_mode = M_GAP;
                        end else begin
                            b.res[b.n] = mk_res(RK_TEXT, c, 12'd1, 8'(n_cnt));
                            b.n = b.n + 2'd1;
                        end
                    end
                end
                M_GAP: begin
                    if (!blank) begin
                        n_mode   = M_ARG;
                        n_inq    = 1'b0;
                        n_qp     = 1'b0;
                        n_run    = '0;
                        do_later = 1'b1;
                    end
                end
                M_ARG: begin
                    if (r_qp) begin
                        n_qp = 1'b0;
                        if (c == CH_QUOTE) begin
                            // doubled quote inside quotes
                            b.res[b.n] = mk_res(RK_TEXT, CH_QUOTE, 12'd1, 8'(n_cnt));
                            b.n = b.n + 2'd1;
                        end else begin
                            n_inq    = 1'b0;
                            do_later = 1'b1;
                        end
                    end else begin
                        do_later = 1'b1;
                    end
                end
                default: begin
                    n_mode = M_LEAD;
                end
            endcase

            if (do_later) begin
                if (c == CH_BSLASH) begin
                    if (n_run < BW'(MAX_BACKSLASH_RUN)) n_run = n_run + BW'(1);
                end else begin
                    if (n_run != '0) begin
                        run_tmp = n_run;
                        n_run   = '0;
                        if (c == CH_QUOTE) begin
                            if ((run_tmp >> 1) != '0) begin
                                b.res[b.n] = mk_res(RK_TEXT, CH_BSLASH,
                                                    12'(run_tmp >> 1), 8'(n_cnt));
                                b.n = b.n + 2'd1;
                            end
                            // odd run escapes the quote
                            if (run_tmp[0]) begin
                                b.res[b.n] = mk_res(RK_TEXT, CH_QUOTE, 12'd1, 8'(n_cnt));
                                b.n  = b.n + 2'd1;
                                stop = 1'b1;
                            end
                        end else begin
                            b.res[b.n] = mk_res(RK_TEXT, CH_BSLASH, 12'(run_tmp), 8'(n_cnt));
                            b.n = b.n + 2'd1;
                        end
                    end
                    if (!stop) begin
                        if (c == CH_QUOTE) begin
                            if (n_inq) n_qp = 1'b1;
                            else       n_inq = 1'b1;
                        end else if (!n_inq && blank) begin
                            b.res[b.n] = mk_res(RK_END_ARG, '0, '0, 8'(n_cnt));
                            b.n = b.n + 2'd1;
                            if (n_cnt < CW'(MAX_ARGS)) n_cnt = n_cnt + CW'(1);
                            n_inq  = 1'b0;
                            n_qp   = 1'b0;
                            n_run  = '0;
                            n_mode = M_GAP;
                        end else begin
                            b.res[b.n] = mk_res(RK_TEXT, c, 12'd1, 8'(n_cnt));
                            b.n = b.n + 2'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_LEAD;
            r_inq  <= 1'b0;
            r_qp   <= 1'b0;
            r_run  <= '0;
            r_cnt  <= '0;
        end else if (acc) begin
            r_mode <= n_mode;
            r_inq  <= n_inq;
            r_qp   <= n_qp;
            r_run  <= n_run;
            r_cnt  <= n_cnt;
        end
    end

    assign i_in.ready = i_q_ready;
    assign o_push     = acc && (b.n != 2'd0);
    assign o_bundle   = b;

endmodule

`default_nettype wire

FILE: design/cla_queue.sv
`default_nettype none

module cla_queue
    import cla_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_bundle  i_bundle,
    output logic          o_ready,
    input  wire logic     i_pop,
    output logic          o_valid,
    output t_bundle       o_bundle
);

    localparam int QAW = $clog2(QUEUE_DEPTH);

    t_bundle        r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + QAW'(1);
            if (i_pop)  r_rp <= r_rp + QAW'(1);
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QAW+1)'(1);
                2'b01:   r_count <= r_count - (QAW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_ready  = (r_count != (QAW+1)'(QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_bundle = r_mem[r_rp];

endmodule

`default_nettype wire

FILE: design/cla_back.sv
`default_nettype none

module cla_back
    import cla_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_q_valid,
    input  wire t_bundle i_bundle,
    output logic         o_pop,
    cla_out_if.source    o_out
);

    t_bundle    r_cur;
    logic       r_valid;
    logic [1:0] r_idx;
    logic       is_last, fin;
    t_res       cur;

    assign cur     = r_cur.res[r_idx];
    assign is_last = (r_idx == 2'(r_cur.n - 2'd1));
    assign fin     = r_valid && o_out.ready && is_last;
    assign o_pop   = i_q_valid && (!r_valid || fin);

    always_ff @(posedge i_clk) begin
        if (o_pop) r_cur <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (fin) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (r_valid && o_out.ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.result_kind = cur.kind;
    assign o_out.out_unit    = cur.unit;
    assign o_out.repeat_res  = cur.rep;
    assign o_out.arg_index   = cur.idx;
    assign o_out.last        = is_last;

endmodule

`default_nettype wire

FILE: design/command_line_argument_splitter_top.sv
// Command-line argument splitter.
// Input channel i_in: one item per code unit (kind 0) or an end of line
// (kind 1). Output channel o_out: text runs, ends of argument and an end of
// line carrying the argument count; last marks the final result of an item.
// The parser classifies an item in the cycle it is accepted and posts its
// results (none to three) as one bundle into a four-entry queue; the output
// stage drains a bundle one result per cycle while the receiver is ready.
// With the queue and output stage empty, the first result of an item is
// written to the queue, then loaded into the output stage, and then offered.
// Throughput: one item per cycle while the receiver is ready and each item
// gives at most one result; an item with k results holds the output until
// all k are taken, which sets the sustained rate. Items giving no result
// (skipped blanks, backslashes held back, quotes) use no queue slot.
// Reset returns the parser to the start of a line and empties the queue.
// When the receiver stalls, results hold on o_out, the queue fills and
// i_in.ready drops once all four entries are taken.
`default_nettype none

module command_line_argument_splitter_top
    import cla_pkg::*;
#(
    parameter int MAX_BACKSLASH_RUN = MAX_BACKSLASH_RUN_DEF,
    parameter int MAX_ARGS          = MAX_ARGS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cla_in_if.sink    i_in,
    cla_out_if.source o_out
);

    logic    push, q_ready, q_valid, pop;
    t_bundle push_b, head_b;

    cla_front #(
        .MAX_BACKSLASH_RUN (MAX_BACKSLASH_RUN),
        .MAX_ARGS          (MAX_ARGS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_bundle  (push_b)
    );

    cla_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_b),
        .o_ready  (q_ready),
        .i_pop    (pop),
        .o_valid  (q_valid),
        .o_bundle (head_b)
    );

    cla_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_bundle  (head_b),
        .o_pop     (pop),
        .o_out     (o_out)
    );

`ifndef ASSERT_OFF
    a_eol_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.result_kind == RK_END_LINE |-> o_out.last)
        else $error("end of line not last result of its item");

    a_bundle_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.last |=> o_out.valid)
        else $error("gap inside a result bundle");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> q_ready && push_b.n != 2'd0)
        else $error("push without room or with empty bundle");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import cla_pkg::*;
();

    typedef struct packed {
        logic        kind;
        logic [15:0] unit;
    } t_line_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] unit;
        logic [11:0] rep;
        logic [7:0]  idx;
        logic        last;
    } t_split_res;

    typedef enum logic [1:0] {
        PM_LEAD,
        PM_PROG,
        PM_GAP,
        PM_LATER
    } t_parse_mode;

    localparam logic KIND_UNIT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    logic i_clk;
    logic i_rst_n;

    cla_in_if  in_if ();
    cla_out_if out_if ();

    command_line_argument_splitter_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    t_line_item pending_units[$];
    t_split_res expected_results[$];
    t_split_res step_results[$];

    int items_total;
    int items_accepted;
    int results_seen;
    int errors;

    // splitter state mirror
    t_parse_mode pmode;
    bit          quoted;
    bit          quote_held;
    int          bs_run;
    int          arg_cnt;

    function automatic bit is_blank(logic [15:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic void post(logic [1:0] k, logic [15:0] u, int rep, int idx);
        t_split_res r;
        r.kind = k;
        r.unit = u;
        r.rep  = rep[11:0];
        r.idx  = idx[7:0];
        r.last = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void clear_parser();
        pmode      = PM_LEAD;
        quoted     = 1'b0;
        quote_held = 1'b0;
        bs_run     = 0;
        arg_cnt    = 0;
    endfunction

    function automatic void close_arg();
        post(RK_END_ARG, 16'h0000, 0, arg_cnt);
        if (arg_cnt < MAX_ARGS_DEF) arg_cnt++;
        quoted     = 1'b0;
        quote_held = 1'b0;
        bs_run     = 0;
    endfunction

    // unit inside a later argument: backslash runs resolve on the next unit
    function automatic void later_unit(logic [15:0] c);
        int run;
        if (c == CH_BSLASH) begin
            if (bs_run < MAX_BACKSLASH_RUN_DEF) bs_run++;
            return;
        end
        if (bs_run > 0) begin
            run    = bs_run;
            bs_run = 0;
            if (c == CH_QUOTE) begin
                if (run / 2 > 0) post(RK_TEXT, CH_BSLASH, run / 2, arg_cnt);
                if (run % 2 == 1) begin
                    post(RK_TEXT, CH_QUOTE, 1, arg_cnt);
                    return;
                end
            end else begin
                post(RK_TEXT, CH_BSLASH, run, arg_cnt);
            end
        end
        if (c == CH_QUOTE) begin
            if (quoted) quote_held = 1'b1;
            else quoted = 1'b1;
            return;
        end
        if (!quoted && is_blank(c)) begin
            close_arg();
            pmode = PM_GAP;
            return;
        end
        post(RK_TEXT, c, 1, arg_cnt);
    endfunction

    function automatic void predict_split(logic kind, logic [15:0] c);
        step_results.delete();
        if (kind == KIND_END) begin
            if (pmode == PM_LATER) begin
                quote_held = 1'b0;
                if (bs_run > 0) post(RK_TEXT, CH_BSLASH, bs_run, arg_cnt);
                close_arg();
            end else if (pmode == PM_LEAD || pmode == PM_PROG) begin
                close_arg();
            end
            post(RK_END_LINE, 16'h0000, 0, arg_cnt);
            clear_parser();
        end else begin
            unique case (pmode)
                PM_LEAD, PM_PROG: begin
                    if (!(pmode == PM_LEAD && is_blank(c))) begin
                        pmode = PM_PROG;
                        if (c == CH_QUOTE) begin
                            quoted = !quoted;
                        end else if (!quoted && is_blank(c)) begin
                            close_arg();
                            pmode = PM_GAP;
                        end else begin
                            post(RK_TEXT, c, 1, arg_cnt);
                        end
                    end
                end
                PM_GAP: begin
                    if (!is_blank(c)) begin
                        pmode      = PM_LATER;
                        quoted     = 1'b0;
                        quote_held = 1'b0;
                        bs_run     = 0;
                        later_unit(c);
                    end
                end
                default: begin
                    if (quote_held) begin
                        quote_held = 1'b0;
                        if (c == CH_QUOTE) begin
                            post(RK_TEXT, CH_QUOTE, 1, arg_cnt);
                        end else begin
                            quoted = 1'b0;
                            later_unit(c);
                        end
                    end else begin
                        later_unit(c);
                    end
                end
            endcase
        end
        if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i]) expected_results.push_back(step_results[i]);
    endfunction

    function automatic void add_unit(logic [15:0] c);
        t_line_item it;
        it.kind = KIND_UNIT;
        it.unit = c;
        pending_units.push_back(it);
    endfunction

    function automatic void add_end();
        t_line_item it;
        it.kind = KIND_END;
        it.unit = 16'($urandom());
        pending_units.push_back(it);
    endfunction

    function automatic logic [15:0] pick_unit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return CH_SPACE;
        if (r < 20) return CH_TAB;
        if (r < 35) return CH_QUOTE;
        if (r < 55) return CH_BSLASH;
        if (r < 90) return 16'h0061 + 16'($urandom_range(0, 25));
        return 16'($urandom_range(0, 65535));
    endfunction

    // sender: bursts with random gaps, holds an item until it is taken
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        t_line_item it;
        if (!i_rst_n) begin
            in_if.valid     <= 1'b0;
            in_if.kind      <= 1'b0;
            in_if.code_unit <= 16'h0000;
            burst_left = $urandom_range(1, 12);
            gap_left   = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_split(in_if.kind, in_if.code_unit);
                items_accepted++;
            end
            if (!(in_if.valid && !in_if.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (pending_units.size() > 0) begin
                    it = pending_units.pop_front();
                    in_if.valid     <= 1'b1;
                    in_if.kind      <= it.kind;
                    in_if.code_unit <= it.unit;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: rotating stall mask, plus long hold-offs to fill the block
    logic [7:0] stall_mask;
    int         mask_left;
    int         hold_left;
    bit         long_hold_done;

    always @(posedge i_clk) begin
        t_split_res want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_mask     = 8'hFF;
            mask_left      = 0;
            hold_left      = 0;
            long_hold_done = 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d unit=%h rep=%0d idx=%0d last=%b",
                             $time, out_if.result_kind, out_if.out_unit,
                             out_if.repeat_res, out_if.arg_index, out_if.last);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_if.result_kind !== want.kind) begin
                        $display("%0t: result_kind expected %0d got %0d",
                                 $time, want.kind, out_if.result_kind);
                        errors++;
                    end
                    if (out_if.out_unit !== want.unit) begin
                        $display("%0t: out_unit expected %h got %h",
                                 $time, want.unit, out_if.out_unit);
                        errors++;
                    end
                    if (out_if.repeat_res !== want.rep) begin
                        $display("%0t: repeat_res expected %0d got %0d",
                                 $time, want.rep, out_if.repeat_res);
                        errors++;
                    end
                    if (out_if.arg_index !== want.idx) begin
                        $display("%0t: arg_index expected %0d got %0d",
                                 $time, want.idx, out_if.arg_index);
                        errors++;
                    end
                    if (out_if.last !== want.last) begin
                        $display("%0t: last expected %b got %b",
                                 $time, want.last, out_if.last);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= 40) begin
                long_hold_done = 1'b1;
                hold_left      = 200;
                out_if.ready <= 1'b0;
            end else if ($urandom_range(0, 799) == 0) begin
                hold_left = 120;
                out_if.ready <= 1'b0;
            end else begin
                if (mask_left == 0) begin
                    mask_left  = 64;
                    stall_mask = ($urandom_range(0, 2) == 0) ? 8'hFF
                                                              : (8'($urandom()) | 8'h01);
                end
                mask_left--;
                out_if.ready <= stall_mask[0];
                stall_mask = {stall_mask[0], stall_mask[7:1]};
            end
        end
    end

    initial begin
        int n;
        int len;
        in_if.valid     = 1'b0;
        in_if.kind      = 1'b0;
        in_if.code_unit = 16'h0000;
        out_if.ready    = 1'b0;
        i_rst_n         = 1'b0;
        items_accepted  = 0;
        results_seen    = 0;
        errors          = 0;
        clear_parser();

        // empty line: program name still counts
        add_end();
        // blanks skipped, quoted blank kept and backslash literal in program name
        add_unit(CH_SPACE);
        add_unit(CH_TAB);
        add_unit(CH_QUOTE);
        add_unit(16'hFFFF);
        add_unit(CH_SPACE);
        add_unit(CH_QUOTE);
        add_unit(CH_BSLASH);
        add_unit(16'h0000);
        add_unit(CH_TAB);
        // odd run before a quote, then even run opening quotes
        add_unit(CH_BSLASH);
        add_unit(CH_BSLASH);
        add_unit(CH_BSLASH);
        add_unit(CH_QUOTE);
        add_unit(CH_BSLASH);
        add_unit(CH_BSLASH);
        add_unit(CH_QUOTE);
        // doubled quote inside quotes, then close and blank
        add_unit(CH_QUOTE);
        add_unit(CH_QUOTE);
        add_unit(CH_QUOTE);
        add_unit(CH_SPACE);
        // end straight after backslashes
        add_unit(16'h0062);
        add_unit(CH_BSLASH);
        add_unit(CH_BSLASH);
        add_end();
        // end with a quote still pending
        add_unit(16'h007A);
        add_unit(CH_SPACE);
        add_unit(CH_QUOTE);
        add_unit(CH_QUOTE);
        add_end();

        // random lines, each terminated, with stray end items as noise
        n = 0;
        while (n < 100) begin
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(2, 6)) add_unit(CH_BSLASH);
                end
                add_unit(pick_unit());
            end
            add_end();
            if ($urandom_range(0, 7) == 0) add_end();
            n += len + 1;
        end
        items_total = pending_units.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_accepted < items_total) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
design/cla_pkg.sv
design/cla_if.sv
design/cla_front.sv
design/cla_queue.sv
design/cla_back.sv
design/command_line_argument_splitter_top.sv
verif/tb_top.sv
